>>> design/request_dedup_replay_cache_core_assert.svh
// Assertion macros for the request dedup replay cache core.
`ifndef REQUEST_DEDUP_REPLAY_CACHE_CORE_ASSERT_SVH
`define REQUEST_DEDUP_REPLAY_CACHE_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define RDRC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define RDRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/rdrc_pkg.sv
// Shared types and codes of the request dedup replay cache.
`default_nettype none
package rdrc_pkg;

  localparam logic [2:0] V_ACCEPTED  = 3'd0;
  localparam logic [2:0] V_COLLISION = 3'd1;
  localparam logic [2:0] V_REPLAY    = 3'd2;
  localparam logic [2:0] V_INFLIGHT  = 3'd3;
  localparam logic [2:0] V_FULL      = 3'd4;
  localparam logic [2:0] V_STORED    = 3'd5;
  localparam logic [2:0] V_UNMATCHED = 3'd6;

  localparam int ST_DONE    = 0;
  localparam int ST_SUCCESS = 1;
  localparam int ST_RUNNING = 2;

  typedef struct packed {
    logic [31:0] rid;
    logic [55:0] cmd;
    logic [63:0] clo;
    logic [63:0] chi;
    logic [4:0]  len;
    logic [10:0] status;
    logic [31:0] result;
  } entry_t;

endpackage
`default_nettype wire

>>> design/request_dedup_replay_cache_core.sv
// Top level of the request dedup replay cache: lookup sequencer around the entry store.
// Channel   Ports                                             Handshake
// request   mode req_id dev_type ... running                  start, accepted when !busy
// result    verdict replay_success/value/error/running        result_valid, one cycle
// A request with a zero id gets its result in the cycle after acceptance.
// Otherwise the sequencer reads the entry store one entry per cycle, in index
// order, until the first hit or the last entry; a miss that claims a slot then
// reads the entry at the slot pointer. The single store read port sets this pace.
// Reset clears the valid bits and slot pointer at once; no clearing pass.
// busy stays high until the result strobe; the receiver cannot stall.
`default_nettype none
module request_dedup_replay_cache_core #(
  parameter int ENTRIES = 64,
  parameter int CONFIG_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [31:0] req_id,
  input  wire logic [7:0]  dev_type,
  input  wire logic [7:0]  target_id,
  input  wire logic [7:0]  action,
  input  wire logic [31:0] value,
  input  wire logic [63:0] config_low,
  input  wire logic [63:0] config_high,
  input  wire logic [4:0]  cfg_len,
  input  wire logic        success,
  input  wire logic [7:0]  err_code,
  input  wire logic        running,
  output logic             result_valid,
  output logic [2:0]       verdict,
  output logic             replay_success,
  output logic [31:0]      replay_value,
  output logic [7:0]       replay_error,
  output logic             replay_running
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam logic [4:0] MAX_LEN = 5'(CONFIG_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SLOT} state_t;

  state_t state;
  logic q_mode;
  logic [31:0] q_rid;
  logic [55:0] q_cmd;
  logic [63:0] q_clo;
  logic [63:0] q_chi;
  logic [4:0] q_len;
  logic q_succ;
  logic [7:0] q_err;
  logic q_run;
  logic [AW-1:0] slot_ptr;

  logic [4:0] len_c;
  logic [63:0] clo_c;
  logic [63:0] chi_c;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_idx;
  rdrc_pkg::entry_t ent;
  rdrc_pkg::entry_t wr_data;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic id_hit;
  logic key_hit;
  logic same;
  logic occupied;
  logic result_valid_next;

  always_comb begin
    len_c = (cfg_len > MAX_LEN) ? MAX_LEN : cfg_len;
    for (int b = 0; b < 8; b++) begin
      clo_c[b*8 +: 8] = (5'(b) < len_c) ? config_low[b*8 +: 8] : 8'd0;
      chi_c[b*8 +: 8] = (5'(b + 8) < len_c) ? config_high[b*8 +: 8] : 8'd0;
    end
  end

  assign busy = (state != S_IDLE);

  assign id_hit  = (ent.rid == q_rid);
  assign key_hit = (ent.cmd[23:0] == q_cmd[23:0]);
  assign same = (ent.cmd == q_cmd) && (ent.len == q_len) &&
                (ent.clo == q_clo) && (ent.chi == q_chi);
  assign occupied = (ent.rid != 32'd0) && !ent.status[rdrc_pkg::ST_DONE];

  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = (rd_idx == LAST) ? slot_ptr : rd_idx + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  result_valid_next = start && (req_id == 32'd0);
      S_SCAN:  result_valid_next = q_mode ? ((id_hit && key_hit) || (rd_idx == LAST)) : id_hit;
      S_SLOT:  result_valid_next = 1'b1;
      default: result_valid_next = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = ent;
    if (state == S_SCAN && q_mode && id_hit && key_hit) begin
      wr_en = 1'b1;
      wr_data.status = {q_err, q_run, q_succ, 1'b1};
      wr_data.result = q_cmd[55:24];
    end else if (state == S_SLOT && !occupied) begin
      wr_en = 1'b1;
      wr_data.rid    = q_rid;
      wr_data.cmd    = q_cmd;
      wr_data.clo    = q_clo;
      wr_data.chi    = q_chi;
      wr_data.len    = q_len;
      wr_data.status = '0;
      wr_data.result = '0;
    end
  end

  rdrc_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (ent),
    .rd_idx  (rd_idx),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_ptr     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q_mode <= mode;
            q_rid  <= req_id;
            q_cmd  <= {value, action, target_id, dev_type};
            q_clo  <= clo_c;
            q_chi  <= chi_c;
            q_len  <= len_c;
            q_succ <= success;
            q_err  <= err_code;
            q_run  <= running;
            replay_success <= 1'b0;
            replay_value   <= '0;
            replay_error   <= '0;
            replay_running <= 1'b0;
            if (req_id == 32'd0) begin
              verdict <= mode ? rdrc_pkg::V_UNMATCHED : rdrc_pkg::V_COLLISION;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (q_mode) begin
            if (id_hit && key_hit) begin
              state <= S_IDLE;
              verdict <= rdrc_pkg::V_STORED;
            end else if (rd_idx == LAST) begin
              state <= S_IDLE;
              verdict <= rdrc_pkg::V_UNMATCHED;
            end
          end else if (id_hit) begin
            state <= S_IDLE;
            if (!same) begin
              verdict <= rdrc_pkg::V_COLLISION;
            end else if (ent.status[rdrc_pkg::ST_DONE]) begin
              verdict <= rdrc_pkg::V_REPLAY;
              replay_success <= ent.status[rdrc_pkg::ST_SUCCESS];
              replay_value   <= ent.result;
              replay_error   <= ent.status[10:3];
              replay_running <= ent.status[rdrc_pkg::ST_RUNNING];
            end else begin
              verdict <= rdrc_pkg::V_INFLIGHT;
            end
          end else if (rd_idx == LAST) begin
            // miss: slot pointer read was issued this cycle
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          state <= S_IDLE;
          slot_ptr <= (slot_ptr == LAST) ? '0 : slot_ptr + 1'b1;
          verdict <= occupied ? rdrc_pkg::V_FULL : rdrc_pkg::V_ACCEPTED;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/rdrc_store.sv
// Entry memory with one registered read port, one write port and reset valid bits.
`default_nettype none
module rdrc_store #(
  parameter int ENTRIES = 64,
  parameter int AW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [AW-1:0]     rd_addr,
  output rdrc_pkg::entry_t       rd_data,
  output logic [AW-1:0]          rd_idx,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire rdrc_pkg::entry_t  wr_data
);

  rdrc_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  rdrc_pkg::entry_t rd_q;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q   <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // an entry never written reads as empty
  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

>>> design/rdrc_checker.sv
// Port-level checker for the request dedup replay cache core, with its bind.
`default_nettype none
`include "request_dedup_replay_cache_core_assert.svh"
module rdrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid,
  input wire logic [2:0]  verdict,
  input wire logic        replay_success,
  input wire logic [31:0] replay_value,
  input wire logic [7:0]  replay_error,
  input wire logic        replay_running
);

  `RDRC_ASSERT_NOW(a_verdict_range, clk, rst, result_valid, verdict <= rdrc_pkg::V_UNMATCHED)
  `RDRC_ASSERT_NOW(a_replay_zero, clk, rst, result_valid && verdict != rdrc_pkg::V_REPLAY, !replay_success && replay_value == 32'd0 && replay_error == 8'd0 && !replay_running)
  `RDRC_ASSERT_NEXT(a_accept_reacts, clk, rst, start && !busy, busy || result_valid)
  `RDRC_ASSERT_NOW(a_result_idle, clk, rst, result_valid, !busy)
  `RDRC_ASSERT_NOW(a_fall_result, clk, rst, $fell(busy), result_valid)

endmodule

bind request_dedup_replay_cache_core rdrc_checker u_rdrc_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .result_valid   (result_valid),
  .verdict        (verdict),
  .replay_success (replay_success),
  .replay_value   (replay_value),
  .replay_error   (replay_error),
  .replay_running (replay_running)
);
`default_nettype wire

>>> verif/rdrc_checker.sv
// Checker for the request dedup replay cache: models the entry store and compares each verdict.
module rdrc_scoreboard #(
  parameter int ENTRIES = 64,
  parameter int CONFIG_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [31:0] req_id,
  input  logic [7:0]  dev_type,
  input  logic [7:0]  target_id,
  input  logic [7:0]  action,
  input  logic [31:0] value,
  input  logic [63:0] config_low,
  input  logic [63:0] config_high,
  input  logic [4:0]  cfg_len,
  input  logic        success,
  input  logic [7:0]  err_code,
  input  logic        running,
  input  logic        result_valid,
  input  logic [2:0]  verdict,
  input  logic        replay_success,
  input  logic [31:0] replay_value,
  input  logic [7:0]  replay_error,
  input  logic        replay_running,
  output int          errors,
  output int          pending,
  output int          n_checked,
  output int          n_replay,
  output int          n_full,
  output int          n_collision,
  output int          n_stored
);

  typedef struct packed {
    logic [2:0]  verdict;
    logic        succ;
    logic [31:0] val;
    logic [7:0]  err;
    logic        run;
  } outcome_t;

  rdrc_pkg::entry_t cache [ENTRIES];
  int       slot_ptr;
  outcome_t outcome_q[$];

  function automatic logic [63:0] byte_mask(input int n);
    if (n <= 0) return 64'd0;
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Apply one request to the modeled store and return the verdict it should get.
  function automatic outcome_t lookup_and_update();
    outcome_t    o;
    int          len;
    logic [63:0] clo;
    logic [63:0] chi;
    logic [23:0] key;
    logic [55:0] cmd;
    int          slot;
    o = '0;
    o.verdict = rdrc_pkg::V_UNMATCHED;
    len = cfg_len > CONFIG_BYTES ? CONFIG_BYTES : int'(cfg_len);
    clo = config_low & byte_mask(len);
    chi = config_high & byte_mask(len > 8 ? len - 8 : 0);
    key = {action, target_id, dev_type};
    cmd = {value, key};
    if (mode) begin
      if (req_id != 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache[i].rid == req_id && cache[i].cmd[23:0] == key) begin
            cache[i].status = {err_code, running, success, 1'b1};
            cache[i].result = value;
            o.verdict = rdrc_pkg::V_STORED;
            break;
          end
        end
      end
      return o;
    end
    if (req_id == 0) begin
      o.verdict = rdrc_pkg::V_COLLISION;
      return o;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache[i].rid == req_id) begin
        if (cache[i].cmd != cmd || cache[i].len != len || cache[i].clo != clo ||
            cache[i].chi != chi) begin
          o.verdict = rdrc_pkg::V_COLLISION;
        end else if (cache[i].status[rdrc_pkg::ST_DONE]) begin
          o.verdict = rdrc_pkg::V_REPLAY;
          o.succ = cache[i].status[rdrc_pkg::ST_SUCCESS];
          o.val = cache[i].result;
          o.err = cache[i].status[10:3];
          o.run = cache[i].status[rdrc_pkg::ST_RUNNING];
        end else begin
          o.verdict = rdrc_pkg::V_INFLIGHT;
        end
        return o;
      end
    end
    slot = slot_ptr;
    slot_ptr = (slot + 1) % ENTRIES;
    // a claimed slot still in flight refuses the request, pointer still advances
    if (cache[slot].rid != 0 && !cache[slot].status[rdrc_pkg::ST_DONE]) begin
      o.verdict = rdrc_pkg::V_FULL;
      return o;
    end
    cache[slot] = '{rid: req_id, cmd: cmd, clo: clo, chi: chi, len: 5'(len),
                    status: '0, result: '0};
    o.verdict = rdrc_pkg::V_ACCEPTED;
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] exp, input logic [31:0] act);
    $display("%0t: %s mismatch: expected %h actual %h", $time, what, exp, act);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t o;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) cache[i] = '0;
      slot_ptr = 0;
      outcome_q.delete();
      errors = 0;
      n_checked = 0;
      n_replay = 0;
      n_full = 0;
      n_collision = 0;
      n_stored = 0;
    end else begin
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with no request waiting, verdict %0d", $time, verdict);
          errors++;
        end else begin
          o = outcome_q.pop_front();
          n_checked++;
          if (o.verdict == rdrc_pkg::V_REPLAY) n_replay++;
          if (o.verdict == rdrc_pkg::V_FULL) n_full++;
          if (o.verdict == rdrc_pkg::V_COLLISION) n_collision++;
          if (o.verdict == rdrc_pkg::V_STORED) n_stored++;
          if (verdict !== o.verdict) report("verdict", 32'(o.verdict), 32'(verdict));
          if (replay_success !== o.succ)
            report("replay_success", 32'(o.succ), 32'(replay_success));
          if (replay_value !== o.val) report("replay_value", o.val, replay_value);
          if (replay_error !== o.err)
            report("replay_error", 32'(o.err), 32'(replay_error));
          if (replay_running !== o.run)
            report("replay_running", 32'(o.run), 32'(replay_running));
        end
      end
      if (start && !busy) outcome_q.push_back(lookup_and_update());
    end
    pending = outcome_q.size();
  end

endmodule

>>> verif/tb.sv
// Testbench top for the request dedup replay cache: request stimulus and final verdict.
module tb;

  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic        mode;
    logic [31:0] rid;
    logic [7:0]  ptype;
    logic [7:0]  res;
    logic [7:0]  act;
    logic [31:0] val;
    logic [63:0] clo;
    logic [63:0] chi;
    logic [4:0]  len;
    logic        succ;
    logic [7:0]  err;
    logic        run;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [31:0] req_id = '0;
  logic [7:0]  dev_type = '0;
  logic [7:0]  target_id = '0;
  logic [7:0]  action = '0;
  logic [31:0] value = '0;
  logic [63:0] config_low = '0;
  logic [63:0] config_high = '0;
  logic [4:0]  cfg_len = '0;
  logic        success = 1'b0;
  logic [7:0]  err_code = '0;
  logic        running = 1'b0;
  logic        result_valid;
  logic [2:0]  verdict;
  logic        replay_success;
  logic [31:0] replay_value;
  logic [7:0]  replay_error;
  logic        replay_running;

  int errors, pending, n_checked, n_replay, n_full, n_collision, n_stored;
  int sent = 0;
  int idle_cycles = 0;
  request_t recent[$];

  always #2 clk = ~clk;

  request_dedup_replay_cache_core dut (.*);

  rdrc_scoreboard checker_i (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t fresh_command();
    request_t r;
    r.mode = 1'b0;
    r.rid = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom;
    if (r.rid == 0) r.rid = 32'd1;
    r.ptype = 8'($urandom);
    r.res = 8'($urandom);
    r.act = 8'($urandom);
    r.val = $urandom;
    r.clo = rand64();
    r.chi = rand64();
    r.len = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    r.succ = 1'($urandom);
    r.err = 8'($urandom);
    r.run = 1'($urandom);
    return r;
  endfunction

  // Drive one request and hold it until the core takes it; start is left high.
  task automatic send(input request_t r);
    start <= 1'b1;
    mode <= r.mode;
    req_id <= r.rid;
    dev_type <= r.ptype;
    target_id <= r.res;
    action <= r.act;
    value <= r.val;
    config_low <= r.clo;
    config_high <= r.chi;
    cfg_len <= r.len;
    success <= r.succ;
    err_code <= r.err;
    running <= r.run;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
    if (r.mode == 1'b0) begin
      recent.push_back(r);
      if (recent.size() > 40) void'(recent.pop_front());
    end
  endtask

  task automatic idle_gap();
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      5, 6, 7: gap = $urandom_range(1, 3);
      8: gap = $urandom_range(4, 20);
      default: gap = $urandom_range(50, 200);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t completion_of(input request_t c);
    request_t r;
    r = c;
    r.mode = 1'b1;
    r.val = $urandom;
    r.succ = 1'($urandom);
    r.err = 8'($urandom);
    r.run = 1'($urandom);
    r.len = 5'($urandom);
    r.clo = rand64();
    r.chi = rand64();
    return r;
  endfunction

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    request_t a, b, r;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero id, both kinds
    a = fresh_command();
    a.rid = '0;
    send(a);
    a.mode = 1'b1;
    send(a);
    // all-ones fields, overlong config length
    a = fresh_command();
    a.rid = '1; a.ptype = '1; a.res = '1; a.act = '1; a.val = '1;
    a.clo = '1; a.chi = '1; a.len = 5'd31;
    send(a);
    send(a);
    send(completion_of(a));
    send(a);
    // overlong length must equal the full length
    b = a;
    b.len = 5'd16;
    send(b);
    b.len = 5'd15;
    send(b);
    // completion that matches nothing
    b = completion_of(fresh_command());
    send(b);
    // bytes beyond the length are ignored on compare
    a = fresh_command();
    a.len = 5'd3;
    a.ptype = '0; a.res = '0; a.act = '0; a.val = '0;
    send(a);
    b = a;
    b.clo[63:24] = ~b.clo[63:24];
    b.chi = ~b.chi;
    send(b);
    r = completion_of(a);
    send(r);
    send(b);
    // repeated completion overwrites
    r = completion_of(a);
    send(r);
    send(a);
    // same id, different action
    b = a;
    b.act = ~b.act;
    send(b);
    b.mode = 1'b1;
    send(b);
    // zero length and length nine
    a = fresh_command();
    a.len = 5'd0;
    send(a);
    a.len = 5'd9;
    send(a);
    drain();

    for (int n = 0; n < 900; n++) begin
      pick = $urandom_range(0, 99);
      if (recent.size() == 0 || pick < 35) begin
        r = fresh_command();
      end else if (pick < 55) begin
        r = recent[$urandom_range(0, recent.size() - 1)];
      end else if (pick < 65) begin
        r = recent[$urandom_range(0, recent.size() - 1)];
        case ($urandom_range(0, 3))
          0: r.val ^= 32'(1) << $urandom_range(0, 31);
          1: r.len = 5'($urandom_range(0, 16));
          2: r.clo ^= 64'(1) << $urandom_range(0, 63);
          default: r.ptype ^= 8'(1) << $urandom_range(0, 7);
        endcase
      end else if (pick < 93) begin
        r = completion_of(recent[$urandom_range(0, recent.size() - 1)]);
      end else if (pick < 97) begin
        r = completion_of(fresh_command());
      end else begin
        r = fresh_command();
        r.rid = '0;
        r.mode = 1'($urandom);
      end
      send(r);
      if (n == 450) drain();
      else idle_gap();
    end

    drain();
    repeat (80) @(posedge clk);
    $display("%0d requests sent, %0d results checked: %0d replays, %0d collisions,",
             sent, n_checked, n_replay, n_collision);
    $display("%0d cache full refusals, %0d completions stored", n_full, n_stored);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
